// ===== rtl/phpc_pkg.sv =====
// Shared constants and types of the polygon half-plane clipper.
`default_nettype none
package phpc_pkg;

  // Coordinate width, signed fixed point
  localparam int COORD_BITS = 24;
  // Width of a coordinate difference
  localparam int DIFF_W     = COORD_BITS + 1;
  // Width of a side value (two products of differences, subtracted)
  localparam int SIDE_W     = 2 * COORD_BITS + 3;
  // Serial step counter width
  localparam int CNT_W      = $clog2(DIFF_W);
  // Input and result payload widths
  localparam int DATA_W     = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W = 3;

  // Configuration register indexes
  localparam logic [1:0] REG_START_X = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_END_X   = 2'd2;
  localparam logic [1:0] REG_END_Y   = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIDE,
    ST_PLAN,
    ST_NEXT,
    ST_DIV,
    ST_PUSH
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/polygon_half_plane_clip.sv =====
// Top level of the polygon half-plane clipper with its bit-serial datapath.
`default_nettype none
// One Sutherland-Hodgman clip stage against the half-plane of the line from
// start to end point; a vertex is inside when its side value is negative.
// Vertices enter one per transaction and the block then works on that vertex
// alone. The side value is formed in a radix-2 serial multiplier; each
// crossing point (at most two per vertex) is formed in a serial
// multiply-divide unit that handles x and y side by side. Results leave
// through an output register, so the next vertex is taken while the last
// result still waits. A final vertex with nothing to emit yields one marker
// result with point_valid low.
module polygon_half_plane_clip (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [phpc_pkg::COORD_BITS-1:0] cfg_data,
  // Vertex stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // in_tdata: vertex_x, vertex_y (from bit 0 up)
  input  wire logic [phpc_pkg::DATA_W-1:0]     in_tdata,
  // in_tlast: last_vertex
  input  wire logic                            in_tlast,
  // Clipped point stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_tdata: point_x, point_y (from bit 0 up)
  output logic [phpc_pkg::DATA_W-1:0]          out_tdata,
  // out_tuser: is_crossing, point_valid, polygon_end (from bit 0 up)
  output logic [phpc_pkg::OUT_USER_W-1:0]      out_tuser,
  // out_tlast: run_last
  output logic                                 out_tlast
);
  import phpc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = DIFF_W;
  localparam int SW = SIDE_W;
  localparam int RW = SIDE_W + 3;

  state_t state_r, state_nxt;

  logic signed [CB-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [CB-1:0] cur_x_r, cur_y_r, prev_x_r, prev_y_r, first_x_r, first_y_r;
  logic                 last_r, have_first_r;
  logic signed [DW-1:0] ux_r, uy_r;
  logic        [DW-1:0] vx_sh_r, vy_sh_r;
  logic signed [SW-1:0] acc_r, cur_side_r, prev_side_r, first_side_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [4:0]           pend_r;

  logic        [DW-1:0] dmx_r, dmy_r, qx_r, qy_r;
  logic                 negx_r, negy_r;
  logic        [SW-1:0] num_r;
  logic        [SW:0]   den_r;
  logic        [RW-1:0] rx_r, ry_r;
  logic signed [CB-1:0] cx_r, cy_r;

  logic [CB-1:0] out_x_r, out_y_r;
  logic          out_cross_r, out_pv_r, out_rl_r, out_pe_r, out_valid_r;

  logic          in_acc, cnt_done, out_free, is_div_step, is_step_a;
  logic [4:0]    pend_rest;

  assign in_acc    = in_tvalid && in_tready;
  assign cnt_done  = (cnt_r == CNT_W'(DW - 1));
  assign out_free  = !out_valid_r || out_tready;
  assign pend_rest = pend_r & (pend_r - 5'd1);
  assign is_step_a   = pend_r[0];
  assign is_div_step = pend_r[0] || (!pend_r[1] && pend_r[2]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SIDE;
      ST_SIDE: if (cnt_done) state_nxt = ST_PLAN;
      ST_PLAN: state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (pend_r == 5'd0) state_nxt = ST_IDLE;
        else if (is_div_step) state_nxt = ST_DIV;
        else state_nxt = ST_PUSH;
      end
      ST_DIV:  if (cnt_done) state_nxt = ST_PUSH;
      ST_PUSH: if (out_free) state_nxt = ST_NEXT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      ex_r <= '0;
      ey_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_X: sx_r <= cfg_data;
        REG_START_Y: sy_r <= cfg_data;
        REG_END_X:   ex_r <= cfg_data;
        REG_END_Y:   ey_r <= cfg_data;
        default:     sx_r <= sx_r;
      endcase
    end
  end

  // Serial side value: Horner over the bits of vy and vx, MSB first
  logic signed [SW-1:0] ux_ext, uy_ext, term_pos, term, acc_nxt;
  always_comb begin
    ux_ext   = {{(SW - DW){ux_r[DW-1]}}, ux_r};
    uy_ext   = {{(SW - DW){uy_r[DW-1]}}, uy_r};
    term_pos = (vy_sh_r[DW-1] ? ux_ext : '0) - (vx_sh_r[DW-1] ? uy_ext : '0);
    term     = (cnt_r == '0) ? -term_pos : term_pos;
    acc_nxt  = (acc_r <<< 1) + term;
  end

  // Crossing operands of the chosen edge
  logic signed [SW-1:0] sel_a, sel_b;
  logic signed [CB-1:0] sel_cx, sel_cy, sel_px, sel_py;
  logic        [SW-1:0] mag_a, mag_b;
  logic signed [DW-1:0] dx, dy;
  always_comb begin
    sel_a  = is_step_a ? cur_side_r : first_side_r;
    sel_b  = is_step_a ? prev_side_r : cur_side_r;
    sel_cx = is_step_a ? cur_x_r : first_x_r;
    sel_cy = is_step_a ? cur_y_r : first_y_r;
    sel_px = is_step_a ? prev_x_r : cur_x_r;
    sel_py = is_step_a ? prev_y_r : cur_y_r;
    mag_a  = sel_a[SW-1] ? SW'(-sel_a) : SW'(sel_a);
    mag_b  = sel_b[SW-1] ? SW'(-sel_b) : SW'(sel_b);
    dx     = {sel_px[CB-1], sel_px} - {sel_cx[CB-1], sel_cx};
    dy     = {sel_py[CB-1], sel_py} - {sel_cy[CB-1], sel_cy};
  end

  // Serial multiply-divide step: r = 2r + bit*num, then take up to two den
  logic [RW-1:0] den_ext, den2_ext, rx2, ry2, rx_nxt, ry_nxt;
  logic [1:0]    dgx, dgy;
  always_comb begin
    den_ext  = RW'(den_r);
    den2_ext = RW'({den_r, 1'b0});
    rx2 = {rx_r[RW-2:0], 1'b0} + (dmx_r[DW-1] ? RW'(num_r) : '0);
    ry2 = {ry_r[RW-2:0], 1'b0} + (dmy_r[DW-1] ? RW'(num_r) : '0);
    if (rx2 >= den2_ext) begin
      dgx = 2'd2; rx_nxt = rx2 - den2_ext;
    end else if (rx2 >= den_ext) begin
      dgx = 2'd1; rx_nxt = rx2 - den_ext;
    end else begin
      dgx = 2'd0; rx_nxt = rx2;
    end
    if (ry2 >= den2_ext) begin
      dgy = 2'd2; ry_nxt = ry2 - den2_ext;
    end else if (ry2 >= den_ext) begin
      dgy = 2'd1; ry_nxt = ry2 - den_ext;
    end else begin
      dgy = 2'd0; ry_nxt = ry2;
    end
  end

  // Crossing point: c moved toward p by the quotient
  logic [DW-1:0] cx_ext, cy_ext, resx, resy;
  always_comb begin
    cx_ext = {cx_r[CB-1], cx_r};
    cy_ext = {cy_r[CB-1], cy_r};
    resx   = negx_r ? cx_ext - qx_r : cx_ext + qx_r;
    resy   = negy_r ? cy_ext - qy_r : cy_ext + qy_r;
  end

  // Vertex state and sequencing flags
  logic an, fneg, f_a, f_b, f_c, f_d;
  always_comb begin
    an   = acc_r[SW-1];
    fneg = have_first_r ? first_side_r[SW-1] : an;
    f_a  = have_first_r && (an != prev_side_r[SW-1]);
    f_b  = have_first_r && an;
    f_c  = last_r && (fneg != an);
    f_d  = last_r && fneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      pend_r       <= '0;
    end else begin
      unique case (state_r)
        ST_PLAN: pend_r <= {last_r && !(f_a || f_b || f_c || f_d), f_d, f_c, f_b, f_a};
        ST_NEXT: if (pend_r == 5'd0) have_first_r <= !last_r;
        ST_PUSH: if (out_free) pend_r <= pend_rest;
        default: pend_r <= pend_r;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cur_x_r <= in_tdata[CB-1:0];
          cur_y_r <= in_tdata[2*CB-1:CB];
          last_r  <= in_tlast;
          ux_r    <= {ex_r[CB-1], ex_r} - {sx_r[CB-1], sx_r};
          uy_r    <= {ey_r[CB-1], ey_r} - {sy_r[CB-1], sy_r};
          vx_sh_r <= {in_tdata[CB-1], in_tdata[CB-1:0]} - {sx_r[CB-1], sx_r};
          vy_sh_r <= {in_tdata[2*CB-1], in_tdata[2*CB-1:CB]} - {sy_r[CB-1], sy_r};
          acc_r   <= '0;
          cnt_r   <= '0;
        end
      end
      ST_SIDE: begin
        acc_r   <= acc_nxt;
        vx_sh_r <= {vx_sh_r[DW-2:0], 1'b0};
        vy_sh_r <= {vy_sh_r[DW-2:0], 1'b0};
        cnt_r   <= cnt_r + CNT_W'(1);
      end
      ST_PLAN: begin
        cur_side_r <= acc_r;
        if (!have_first_r) begin
          first_x_r    <= cur_x_r;
          first_y_r    <= cur_y_r;
          first_side_r <= acc_r;
        end
      end
      ST_NEXT: begin
        if (pend_r == 5'd0) begin
          prev_x_r    <= cur_x_r;
          prev_y_r    <= cur_y_r;
          prev_side_r <= cur_side_r;
        end else if (is_div_step) begin
          num_r  <= mag_a;
          den_r  <= {1'b0, mag_a} + {1'b0, mag_b};
          negx_r <= dx[DW-1];
          negy_r <= dy[DW-1];
          dmx_r  <= dx[DW-1] ? DW'(-dx) : DW'(dx);
          dmy_r  <= dy[DW-1] ? DW'(-dy) : DW'(dy);
          cx_r   <= sel_cx;
          cy_r   <= sel_cy;
          rx_r   <= '0;
          ry_r   <= '0;
          qx_r   <= '0;
          qy_r   <= '0;
          cnt_r  <= '0;
        end
      end
      ST_DIV: begin
        rx_r  <= rx_nxt;
        ry_r  <= ry_nxt;
        qx_r  <= {qx_r[DW-2:0], 1'b0} + DW'(dgx);
        qy_r  <= {qy_r[DW-2:0], 1'b0} + DW'(dgy);
        dmx_r <= {dmx_r[DW-2:0], 1'b0};
        dmy_r <= {dmy_r[DW-2:0], 1'b0};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      default: cnt_r <= cnt_r;
    endcase
  end

  // Output register: load a result, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_PUSH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PUSH && out_free) begin
      out_rl_r <= (pend_rest == 5'd0);
      out_pe_r <= last_r && (pend_rest == 5'd0);
      priority if (is_div_step) begin
        out_x_r <= resx[CB-1:0];
        out_y_r <= resy[CB-1:0];
        out_cross_r <= 1'b1;
        out_pv_r <= 1'b1;
      end else if (pend_r[1]) begin
        out_x_r <= cur_x_r;
        out_y_r <= cur_y_r;
        out_cross_r <= 1'b0;
        out_pv_r <= 1'b1;
      end else if (pend_r[3]) begin
        out_x_r <= first_x_r;
        out_y_r <= first_y_r;
        out_cross_r <= 1'b0;
        out_pv_r <= 1'b1;
      end else begin
        out_x_r <= '0;
        out_y_r <= '0;
        out_cross_r <= 1'b0;
        out_pv_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({out_y_r, out_x_r});
  assign out_tuser  = {out_pe_r, out_pv_r, out_cross_r};
  assign out_tlast  = out_rl_r;

endmodule
`default_nettype wire
